FILE: hw/rtl/tss_pkg.sv
package tss_pkg;

    localparam int TEMP_W   = 21;
    localparam int SUM_W    = 21;
    localparam int TENTHS_W = 14;
    localparam int WHOLE_W  = 10;

    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] SEG_DASH  = 8'h40;
    localparam logic [7:0] SEG_POINT = 8'h80;

    localparam logic [1:0] STATUS_SHOWN      = 2'd0;
    localparam logic [1:0] STATUS_NO_READING = 2'd1;
    localparam logic [1:0] STATUS_TOO_WIDE   = 2'd2;

    typedef struct packed {
        logic tvalid;
        logic neg;
        logic too_wide;
    } t_flags;

    typedef struct packed {
        t_flags               flags;
        logic [WHOLE_W-1:0]   whole;
        logic [TENTHS_W-1:0]  tenths;
    } t_scaled;

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0: seg = 8'h3f;
            4'd1: seg = 8'h06;
            4'd2: seg = 8'h5b;
            4'd3: seg = 8'h4f;
            4'd4: seg = 8'h66;
            4'd5: seg = 8'h6d;
            4'd6: seg = 8'h7d;
            4'd7: seg = 8'h07;
            4'd8: seg = 8'h7f;
            4'd9: seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

FILE: hw/rtl/tss_scale.sv
module tss_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [tss_pkg::TEMP_W-1:0] i_temp,
    input  logic                          i_temp_valid,
    output logic                          o_valid,
    output tss_pkg::t_scaled              o_data
);

    // x / 100 for x < 2^20: (x * ceil(2^27 / 100)) >> 27
    localparam logic [40:0] RECIP_100 = 41'd1342178;
    // t / 10 for t < 2^14: (t * ceil(2^17 / 10)) >> 17
    localparam logic [27:0] RECIP_10  = 28'd13108;

    // stage 1: magnitude plus rounding bias
    logic                         r_s1_valid;
    logic                         r_s1_tvalid;
    logic                         r_s1_below;
    logic [tss_pkg::SUM_W-1:0]    r_s1_sum;
    logic [tss_pkg::SUM_W-1:0]    n_s1_sum;
    logic [tss_pkg::TEMP_W-1:0]   w_raw;

    // stage 2: tenths and width check
    logic                         r_s2_valid;
    logic                         r_s2_tvalid;
    logic                         r_s2_below;
    logic                         r_s2_too_wide;
    logic [tss_pkg::TENTHS_W-1:0] r_s2_tenths;
    logic [40:0]                  w_prod100;
    logic                         n_s2_too_wide;

    // stage 3: whole degrees
    logic                         r_s3_valid;
    tss_pkg::t_scaled             r_s3_data;
    tss_pkg::t_scaled             n_s3_data;
    logic [27:0]                  w_prod10;

    always_comb begin
        w_raw    = i_temp;
        n_s1_sum = (w_raw[tss_pkg::TEMP_W-1] ? (~w_raw + 21'd1) : w_raw) + 21'd50;
    end

    always_comb begin
        w_prod100     = 41'(r_s1_sum[19:0]) * RECIP_100;
        n_s2_too_wide = (r_s1_sum >= 21'd1000000) || (r_s1_below && (r_s1_sum >= 21'd100000));
    end

    always_comb begin
        w_prod10                = 28'(r_s2_tenths) * RECIP_10;
        n_s3_data.flags.tvalid  = r_s2_tvalid;
        n_s3_data.flags.neg     = r_s2_below && (r_s2_tenths != '0);
        n_s3_data.flags.too_wide = r_s2_too_wide;
        n_s3_data.whole         = w_prod10[26:17];
        n_s3_data.tenths        = r_s2_tenths;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tvalid   <= i_temp_valid;
        r_s1_below    <= w_raw[tss_pkg::TEMP_W-1];
        r_s1_sum      <= n_s1_sum;
        r_s2_tvalid   <= r_s1_tvalid;
        r_s2_below    <= r_s1_below;
        r_s2_too_wide <= n_s2_too_wide;
        r_s2_tenths   <= w_prod100[40:27];
        r_s3_data     <= n_s3_data;
    end

    assign o_valid = r_s3_valid;
    assign o_data  = r_s3_data;

endmodule

FILE: hw/rtl/temperature_to_seven_segment.sv
// Temperature to seven-segment formatter for one four-cell display group.
// Input: pulse start with i_temp_millicelsius (signed, millidegrees) and
// i_temp_valid. A transfer happens at a clock edge where start is high and
// busy is low. busy is low whenever reset is released, so a new value may
// be sent every cycle.
// Output: o_strobe is high for one cycle with the four segment bytes
// (bit 7 = decimal point) and o_display_status (0 shown, 1 no reading,
// 2 too wide). Results come out in input order.
// Pipeline: seven register stages lie between the input transfer and the
// outputs (magnitude, divide by 100, divide by 10, hundreds, remainder,
// tens, cell formatting).
// Throughput: one value per cycle; every stage is a plain register stage.
// Reset: synchronous, active low; clears all stage valid bits, so no
// strobe follows reset until a new transfer. The receiver cannot stall:
// each result is valid for its strobe cycle only.
module temperature_to_seven_segment (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tss_pkg::TEMP_W-1:0]     i_temp_millicelsius,
    input  logic                                  i_temp_valid,
    output logic                                  o_strobe,
    output logic [7:0]                            o_cell_leftmost,
    output logic [7:0]                            o_cell_second,
    output logic [7:0]                            o_cell_third,
    output logic [7:0]                            o_cell_rightmost,
    output logic [1:0]                            o_display_status
);

    logic                          w_accept;
    logic                          w_sc_valid;
    tss_pkg::t_scaled              w_sc_data;

    // stage 4: tenths digit, hundreds digit
    logic                          r_s4_valid;
    tss_pkg::t_flags               r_s4_flags;
    logic [tss_pkg::WHOLE_W-1:0]   r_s4_whole;
    logic [3:0]                    r_s4_frac;
    logic [3:0]                    r_s4_hund;
    logic [tss_pkg::TENTHS_W-1:0]  w_whole10;
    logic [15:0]                   w_prod41;

    // stage 5: remainder below 100
    logic                          r_s5_valid;
    tss_pkg::t_flags               r_s5_flags;
    logic [3:0]                    r_s5_frac;
    logic [3:0]                    r_s5_hund;
    logic [6:0]                    r_s5_rem;
    logic [tss_pkg::WHOLE_W-1:0]   w_hund100;

    // stage 6: tens digit
    logic                          r_s6_valid;
    tss_pkg::t_flags               r_s6_flags;
    logic [3:0]                    r_s6_frac;
    logic [3:0]                    r_s6_hund;
    logic [6:0]                    r_s6_rem;
    logic [3:0]                    r_s6_tens;
    logic [14:0]                   w_prod205;

    // stage 7: cells
    logic [6:0]                    w_tens10;
    logic [3:0]                    w_ones;
    logic                          w_has3;
    logic                          w_has2;
    logic [7:0]                    n_cell0;
    logic [7:0]                    n_cell1;
    logic [7:0]                    n_cell2;
    logic [7:0]                    n_cell3;
    logic [1:0]                    n_status;
    logic                          r_strobe;
    logic [7:0]                    r_cell0;
    logic [7:0]                    r_cell1;
    logic [7:0]                    r_cell2;
    logic [7:0]                    r_cell3;
    logic [1:0]                    r_status;

    assign busy     = ~i_rst_n;
    assign w_accept = start && !busy;

    tss_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_temp       (i_temp_millicelsius),
        .i_temp_valid (i_temp_valid),
        .o_valid      (w_sc_valid),
        .o_data       (w_sc_data)
    );

    always_comb begin
        w_whole10 = 14'({w_sc_data.whole, 3'b000}) + 14'({w_sc_data.whole, 1'b0});
        w_prod41  = 16'(w_sc_data.whole) * 16'd41;
    end

    always_comb begin
        w_hund100 = 10'({r_s4_hund, 6'b0}) + 10'({r_s4_hund, 5'b0}) + 10'({r_s4_hund, 2'b0});
    end

    always_comb begin
        w_prod205 = 15'(r_s5_rem) * 15'd205;
    end

    always_comb begin
        w_tens10 = 7'({r_s6_tens, 3'b000}) + 7'({r_s6_tens, 1'b0});
        w_ones   = 4'(r_s6_rem - w_tens10);
        w_has3   = (r_s6_hund != 4'd0);
        w_has2   = w_has3 || (r_s6_tens != 4'd0);
        n_cell3  = tss_pkg::glyph(r_s6_frac);
        n_cell2  = tss_pkg::glyph(w_ones) | tss_pkg::SEG_POINT;
        if (w_has2) begin
            n_cell1 = tss_pkg::glyph(r_s6_tens);
        end else if (r_s6_flags.neg) begin
            n_cell1 = tss_pkg::SEG_DASH;
        end else begin
            n_cell1 = tss_pkg::SEG_BLANK;
        end
        if (w_has3) begin
            n_cell0 = tss_pkg::glyph(r_s6_hund);
        end else if (w_has2 && r_s6_flags.neg) begin
            n_cell0 = tss_pkg::SEG_DASH;
        end else begin
            n_cell0 = tss_pkg::SEG_BLANK;
        end
        n_status = tss_pkg::STATUS_SHOWN;
        if (!r_s6_flags.tvalid || r_s6_flags.too_wide) begin
            n_cell0  = tss_pkg::SEG_DASH;
            n_cell1  = tss_pkg::SEG_DASH;
            n_cell2  = tss_pkg::SEG_DASH;
            n_cell3  = tss_pkg::SEG_DASH;
            n_status = r_s6_flags.tvalid ? tss_pkg::STATUS_TOO_WIDE
                                         : tss_pkg::STATUS_NO_READING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s4_valid <= w_sc_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_strobe   <= r_s6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_flags <= w_sc_data.flags;
        r_s4_whole <= w_sc_data.whole;
        r_s4_frac  <= 4'(w_sc_data.tenths - w_whole10);
        r_s4_hund  <= w_prod41[15:12];
        r_s5_flags <= r_s4_flags;
        r_s5_frac  <= r_s4_frac;
        r_s5_hund  <= r_s4_hund;
        r_s5_rem   <= 7'(r_s4_whole - w_hund100);
        r_s6_flags <= r_s5_flags;
        r_s6_frac  <= r_s5_frac;
        r_s6_hund  <= r_s5_hund;
        r_s6_rem   <= r_s5_rem;
        r_s6_tens  <= w_prod205[14:11];
        r_cell0    <= n_cell0;
        r_cell1    <= n_cell1;
        r_cell2    <= n_cell2;
        r_cell3    <= n_cell3;
        r_status   <= n_status;
    end

    assign o_strobe         = r_strobe;
    assign o_cell_leftmost  = r_cell0;
    assign o_cell_second    = r_cell1;
    assign o_cell_third     = r_cell2;
    assign o_cell_rightmost = r_cell3;
    assign o_display_status = r_status;

    a_transfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##7 o_strobe)
        else $error("transfer without result");

    a_no_reading_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_temp_valid) |->
            ##7 (o_strobe && o_display_status == tss_pkg::STATUS_NO_READING))
        else $error("missing reading not flagged");

    a_dashes_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_display_status != tss_pkg::STATUS_SHOWN) |->
            (o_cell_leftmost == tss_pkg::SEG_DASH && o_cell_second == tss_pkg::SEG_DASH &&
             o_cell_third == tss_pkg::SEG_DASH && o_cell_rightmost == tss_pkg::SEG_DASH))
        else $error("error result not all dashes");

    a_point_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_display_status == tss_pkg::STATUS_SHOWN) |->
            (o_cell_third[7] && !o_cell_rightmost[7] && !o_cell_second[7] &&
             !o_cell_leftmost[7]))
        else $error("decimal point misplaced");

endmodule
